[rtl/spf_pkg.sv]
// Shared types, constants and the CRC byte update for the space packet framer.
package spf_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [7:0] REG_VERSION   = 8'd0;
    localparam logic [7:0] REG_TYPE      = 8'd1;
    localparam logic [7:0] REG_SEC_HDR   = 8'd2;
    localparam logic [7:0] REG_APID      = 8'd3;
    localparam logic [7:0] REG_SEQ_FLAGS = 8'd4;

    // Byte positions inside one command's expansion.
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_W1_HI     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_W1_LO     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_W2_HI     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_W2_LO     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LEN_HI    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LEN_LO    = 3'd5;
    localparam logic [STEP_W-1:0] START_CRC_STEP = 3'd6;
    localparam logic [STEP_W-1:0] DATA_CRC_STEP  = 3'd1;

    typedef struct packed {
        logic [2:0]  version;
        logic        ptype;
        logic        sec_hdr;
        logic [10:0] apid;
        logic [1:0]  seq_flags;
    } cfg_t;

    // One unit of work for the back end: a header or a payload byte,
    // optionally followed by the two CRC bytes that close the packet.
    typedef struct packed {
        logic        is_start;
        logic        append_crc;
        logic [13:0] seq_count;
        logic [15:0] length;
        logic [7:0]  data;
    } cmd_t;

    // CRC-16/CCITT, MSB first, one byte per call.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/spf_front.sv]
// Front end: accepts input words, tracks the open packet and queues commands.
module spf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  logic [39:0]         s_tdata,
    input  logic                q_full,
    output logic                q_push,
    output spf_pkg::cmd_t       q_data
);

    logic        in_packet_reg, in_packet_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        accept;
    logic [13:0] seq_count;
    logic [15:0] length;
    logic [7:0]  data_byte;

    assign seq_count = s_tdata[13:0];
    assign length    = s_tdata[29:14];
    assign data_byte = s_tdata[37:30];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_packet_next       = in_packet_reg;
        remaining_next       = remaining_reg;
        q_push               = 1'b0;
        q_data.is_start      = 1'b0;
        q_data.append_crc    = 1'b0;
        q_data.seq_count     = seq_count;
        q_data.length        = length;
        q_data.data          = data_byte;
        if (accept) begin
            if (!s_tuser) begin
                // A start abandons any open packet.
                q_push          = 1'b1;
                q_data.is_start = 1'b1;
                if (length <= 16'd1) begin
                    q_data.append_crc = 1'b1;
                    in_packet_next    = 1'b0;
                    remaining_next    = '0;
                end else begin
                    in_packet_next = 1'b1;
                    remaining_next = length - 16'd1;
                end
            end else if (in_packet_reg) begin
                q_push            = 1'b1;
                q_data.append_crc = (remaining_reg == 16'd1);
                remaining_next    = remaining_reg - 16'd1;
                if (remaining_reg == 16'd1) begin
                    in_packet_next = 1'b0;
                end
            end
            // Data words outside a packet are dropped.
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg <= 1'b0;
            remaining_reg <= '0;
        end else begin
            in_packet_reg <= in_packet_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

[rtl/spf_cmd_queue.sv]
// Small register FIFO of commands between the front and back ends.
module spf_cmd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  spf_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output spf_pkg::cmd_t pop_data,
    output logic          empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    spf_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/spf_back.sv]
// Back end: expands commands into framed bytes, runs the CRC, drives the output.
module spf_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  spf_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    input  spf_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);

    logic [spf_pkg::STEP_W-1:0] step_reg, step_next;
    logic [spf_pkg::STEP_W-1:0] crc_step, final_step;
    logic [15:0] crc_reg, crc_next, crc_in;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        fire, is_crc, is_crc_lo;
    logic [15:0] w1, w2;
    logic [7:0]  hdr_byte, out_byte;

    assign w1 = {cfg.version, cfg.ptype, cfg.sec_hdr, cfg.apid};
    assign w2 = {cfg.seq_flags, cmd.seq_count};

    assign crc_step   = cmd.is_start ? spf_pkg::START_CRC_STEP : spf_pkg::DATA_CRC_STEP;
    assign final_step = cmd.append_crc ? crc_step + 1'b1 : crc_step - 1'b1;
    assign is_crc     = cmd.append_crc && (step_reg >= crc_step);
    assign is_crc_lo  = is_crc && (step_reg != crc_step);

    always_comb begin
        unique case (step_reg)
            spf_pkg::STEP_W1_HI:  hdr_byte = w1[15:8];
            spf_pkg::STEP_W1_LO:  hdr_byte = w1[7:0];
            spf_pkg::STEP_W2_HI:  hdr_byte = w2[15:8];
            spf_pkg::STEP_W2_LO:  hdr_byte = w2[7:0];
            spf_pkg::STEP_LEN_HI: hdr_byte = cmd.length[15:8];
            spf_pkg::STEP_LEN_LO: hdr_byte = cmd.length[7:0];
            default:              hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        if (is_crc) begin
            out_byte = is_crc_lo ? crc_reg[7:0] : crc_reg[15:8];
        end else if (cmd.is_start) begin
            out_byte = hdr_byte;
        end else begin
            out_byte = cmd.data;
        end
    end

    // The CRC restarts with the first header byte of every packet.
    assign crc_in = (cmd.is_start && step_reg == spf_pkg::STEP_W1_HI) ?
                    spf_pkg::CRC_INIT : crc_reg;

    assign fire    = cmd_valid && (!m_tvalid_reg || m_tready);
    assign cmd_pop = fire && (step_reg == final_step);

    always_comb begin
        step_next     = step_reg;
        crc_next      = crc_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = out_byte;
            m_tlast_next  = is_crc_lo;
            step_next     = cmd_pop ? '0 : step_reg + 1'b1;
            if (is_crc_lo) begin
                crc_next = spf_pkg::CRC_INIT;
            end else if (!is_crc) begin
                crc_next = spf_pkg::crc_feed(crc_in, out_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            crc_reg      <= spf_pkg::CRC_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            crc_reg      <= crc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Closing a packet always returns the CRC to its initial value.
    a_crc_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_crc_lo) |=> (crc_reg == spf_pkg::CRC_INIT))
        else $error("CRC not restarted after packet end");

    // The step counter never runs past the end of the current command.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid |-> (step_reg <= final_step))
        else $error("step counter past end of command");

    // The CRC low byte is always the last byte of its command.
    a_end_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_crc_lo) |-> cmd_pop)
        else $error("packet end without command retire");

endmodule

[rtl/space_packet_framer_crc16_unit.sv]
// Top level of the space packet framer with CRC-16: config registers and wiring.
//
// Input words arrive on the s_ stream. s_tuser is the kind: 0 starts a packet
// (sequence count and length field in s_tdata), 1 carries a payload byte.
// A start word produces the six big-endian header bytes; then length minus one
// payload words pass through, and the CRC-16/CCITT (init 0xFFFF) over every
// byte of the packet follows, high byte first, with m_tlast on the low byte.
// A length of 0 or 1 puts the CRC right after the header. Payload words that
// arrive with no packet open are accepted and dropped.
// The front end classifies each word and queues a command; the back end turns
// one command into bytes, one byte per cycle unless the output stalls, into an
// output register, which a word's command reaches through the queue. Payload
// streams through at one word per cycle unless stalled; a start word occupies
// the output for its six header bytes (and two CRC bytes with a short length),
// and the queue of QUEUE_DEPTH commands keeps taking words meanwhile. When the
// receiver stalls, the output register holds its word and the queue fills;
// s_tready drops only once it is full. Reset (synchronous, aresetn low) empties
// the queue, closes any packet, sets the CRC to 0xFFFF and returns the registers
// to their defaults (sequence flags 3, all others 0). Configuration is written
// through cfg_* while idle: a duty of the user that the block does not enforce.
module space_packet_framer_crc16_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // kind
    input  logic [39:0] s_tdata,   // sequence_count[13:0], length_field[29:14],
                                   // data_byte[37:30], zero[39:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // packet_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    spf_pkg::cfg_t cfg_reg;
    spf_pkg::cmd_t push_cmd, head_cmd;
    logic          q_push, q_full, q_pop, q_empty;

    // Register writes complete in the cycle they are offered. Only the low
    // bits that fit each register are kept; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.version   <= '0;
            cfg_reg.ptype     <= 1'b0;
            cfg_reg.sec_hdr   <= 1'b0;
            cfg_reg.apid      <= '0;
            cfg_reg.seq_flags <= 2'b11;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                spf_pkg::REG_VERSION:   cfg_reg.version   <= cfg_data[2:0];
                spf_pkg::REG_TYPE:      cfg_reg.ptype     <= cfg_data[0];
                spf_pkg::REG_SEC_HDR:   cfg_reg.sec_hdr   <= cfg_data[0];
                spf_pkg::REG_APID:      cfg_reg.apid      <= cfg_data[10:0];
                spf_pkg::REG_SEQ_FLAGS: cfg_reg.seq_flags <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    spf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_cmd)
    );

    spf_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_cmd),
        .empty     (q_empty)
    );

    spf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (!q_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[dv/spf_tb_pkg.sv]
// Scoreboard for the space packet framer testbench: header and CRC prediction plus byte checks.
package spf_tb_pkg;

    import spf_pkg::*;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // First register index that maps to no register at all.
    localparam logic [7:0] REG_UNUSED = REG_SEQ_FLAGS + 8'd1;

    typedef struct packed {
        logic [7:0] octet;
        logic       frame_end;
    } framed_byte_t;

    class spf_scoreboard;
        logic [2:0]   version;
        logic         ptype;
        logic         sec_hdr;
        logic [10:0]  apid;
        logic [1:0]   seq_flags;

        logic [15:0]  crc;
        logic [15:0]  remaining;
        bit           packet_open;

        framed_byte_t expected_bytes[$];

        int errors;
        int bytes_checked;
        int packets_closed;
        int short_packets;
        int abandoned;
        int strays;

        function new();
            version     = '0;
            ptype       = 1'b0;
            sec_hdr     = 1'b0;
            apid        = '0;
            seq_flags   = 2'd3;
            crc         = CRC_INIT;
            remaining   = '0;
            packet_open = 1'b0;
        endfunction

        function void write_reg(input logic [7:0] idx, input logic [15:0] val);
            case (idx)
                REG_VERSION:   version   = val[2:0];
                REG_TYPE:      ptype     = val[0];
                REG_SEC_HDR:   sec_hdr   = val[0];
                REG_APID:      apid      = val[10:0];
                REG_SEQ_FLAGS: seq_flags = val[1:0];
                default: ;
            endcase
        endfunction

        // Queue one framed byte and fold it into the running CRC, MSB first.
        function void emit(input logic [7:0] b);
            logic fb;
            expected_bytes.push_back('{octet: b, frame_end: 1'b0});
            for (int i = 7; i >= 0; i--) begin
                fb  = crc[15] ^ b[i];
                crc = {crc[14:0], 1'b0};
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
            end
        endfunction

        function void close_packet();
            expected_bytes.push_back('{octet: crc[15:8], frame_end: 1'b0});
            expected_bytes.push_back('{octet: crc[7:0], frame_end: 1'b1});
            crc         = CRC_INIT;
            remaining   = '0;
            packet_open = 1'b0;
            packets_closed++;
        endfunction

        function void note_word(input logic kind, input logic [13:0] seq,
                                input logic [15:0] len, input logic [7:0] data);
            logic [15:0] id_word;
            logic [15:0] seq_word;
            if (kind == KIND_START) begin
                if (packet_open) begin
                    abandoned++;
                end
                id_word  = {version, ptype, sec_hdr, apid};
                seq_word = {seq_flags, seq};
                crc = CRC_INIT;
                emit(id_word[15:8]);
                emit(id_word[7:0]);
                emit(seq_word[15:8]);
                emit(seq_word[7:0]);
                emit(len[15:8]);
                emit(len[7:0]);
                if (len <= 16'd1) begin
                    short_packets++;
                    close_packet();
                end else begin
                    remaining   = len - 16'd1;
                    packet_open = 1'b1;
                end
            end else if (!packet_open) begin
                strays++;
            end else begin
                emit(data);
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) begin
                    close_packet();
                end
            end
        endfunction

        function void check_byte(input logic [7:0] b, input logic fin);
            framed_byte_t want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h tlast %0b",
                         $time, b, fin);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (b !== want.octet) begin
                $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                         $time, want.octet, b);
                errors++;
            end
            if (fin !== want.frame_end) begin
                $display("%0t: packet_end mismatch, expected %0b, actual %0b",
                         $time, want.frame_end, fin);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void report_leftover();
            if (expected_bytes.size() != 0) begin
                $display("%0t: %0d bytes never arrived, expected next %02h tlast %0b",
                         $time, expected_bytes.size(), expected_bytes[0].octet,
                         expected_bytes[0].frame_end);
                errors++;
            end
        endfunction
    endclass

endpackage

[dv/tb_space_packet_framer_crc16_unit.sv]
// Testbench for space_packet_framer_crc16_unit: directed and random packets checked byte by byte.
//
// Every accepted input word is handed to a scoreboard that builds the six header bytes from
// its own copy of the configuration, tracks the running CRC-16/CCITT and the payload count,
// and queues every byte the framer should send. Each byte leaving the block is compared with
// the oldest queued one, data and tlast separately. The run starts with a short directed part
// (short lengths, the largest length, stray payload, a start inside an open packet, ignored
// fields set) and then moves through several random phases, each under new header settings.
module tb_space_packet_framer_crc16_unit;

    import spf_pkg::*;
    import spf_tb_pkg::*;

    localparam int WORDS_PER_PHASE = 40;
    localparam int RANDOM_PHASES   = 4;
    // Room for the queue and output registers plus a full queue of dropped payload words.
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_LIMIT     = 20000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic        s_tuser   = KIND_START;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    spf_scoreboard sb;

    // When set, neither side inserts gaps, so the block runs at full rate.
    bit steady = 1'b0;
    int stall_left = 0;
    int cfg_writes = 0;
    int random_words = 0;
    bit big_done = 1'b0;

    space_packet_framer_crc16_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return $urandom_range(2, 1);
        end
        if (r < 93) begin
            return $urandom_range(6, 3);
        end
        return $urandom_range(40, 12);
    endfunction

    // The receiver stalls at random unless the steady stretch is on.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(99) < 20) begin
                stall_left <= gap_length();
            end
        end
    end

    // Outputs are sampled at the edge, before the block's own updates land.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_byte(m_tdata, m_tlast);
        end
    end

    // Drive one word and wait for it to be taken. Valid stays high afterwards so that
    // back-to-back words never lower and raise it in the same step; a gap lowers it.
    task automatic send_word(input logic kind, input logic [13:0] seq,
                             input logic [15:0] len, input logic [7:0] data);
        int gap;
        gap = (steady || $urandom_range(99) < 55) ? 0 : gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, data, len, seq};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(kind, seq, len, data);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_writes++;
    endtask

    // Stop sending, let every expected byte come out and the block settle, then load a new
    // header setup. One write also goes to an index that has no register behind it.
    task automatic program_header(input logic [15:0] ver, input logic [15:0] pkt_type,
                                  input logic [15:0] sec, input logic [15:0] app_id,
                                  input logic [15:0] flags);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_VERSION, ver);
        write_reg(REG_TYPE, pkt_type);
        write_reg(REG_SEC_HDR, sec);
        write_reg(REG_APID, app_id);
        write_reg(REG_SEQ_FLAGS, flags);
        write_reg(8'($urandom_range(255, REG_UNUSED)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int          pick;
        int          ndata;
        int          drain;
        int          phase_base;
        logic [15:0] len;
        bit          abandon;

        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset configuration (sequence flags 3, all else 0).
        // Short lengths close the packet right after the header; data_byte is ignored.
        send_word(KIND_START, 14'h0000, 16'h0000, 8'hFF);
        send_word(KIND_START, 14'h3FFF, 16'h0001, 8'h00);
        // A payload word with no open packet is dropped; its unused fields are all ones.
        send_word(KIND_DATA, 14'h3FFF, 16'hFFFF, 8'hAA);
        send_word(KIND_START, 14'h1555, 16'h0002, 8'h00);
        send_word(KIND_DATA, 14'h2AAA, 16'h8000, 8'hFF);
        // The largest length, abandoned after a few bytes by a new start word.
        send_word(KIND_START, 14'h2AAA, 16'hFFFF, 8'h00);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'h00);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'h80);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'h01);
        send_word(KIND_START, 14'h0001, 16'h0004, 8'h00);
        send_word(KIND_DATA, 14'h1234, 16'h5678, 8'h7F);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'h5A);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'hC3);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'h00);

        // Every register at its top value, with junk in the unused upper bits.
        program_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(KIND_START, 14'h3FFF, 16'h0000, 8'h00);
        send_word(KIND_START, 14'h0000, 16'h0003, 8'h00);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'hFF);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'h00);

        // Every register at zero, sequence flags included.
        program_header(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_word(KIND_START, 14'h2000, 16'h0001, 8'h00);
        send_word(KIND_START, 14'h0100, 16'h0002, 8'h00);
        send_word(KIND_DATA, 14'h0000, 16'h0000, 8'h3C);

        // Random phases. Most traffic is well-formed packets with random content; the rest is
        // stray payload, abandoned packets with wild lengths and one long payload run.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_header(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom));
            steady = (phase == 1);
            phase_base = random_words;
            while (random_words - phase_base < WORDS_PER_PHASE) begin
                pick    = $urandom_range(99);
                abandon = 1'b0;
                if (pick < 6 && !sb.packet_open) begin
                    repeat ($urandom_range(3, 1)) begin
                        send_word(KIND_DATA, 14'($urandom_range(16383)),
                                  16'($urandom_range(65535)), 8'($urandom_range(255)));
                    end
                    continue;
                end
                if (phase == 2 && !big_done) begin
                    // Long enough to carry the payload count above one byte.
                    len      = 16'($urandom_range(264, 257));
                    big_done = 1'b1;
                end else if (pick < 14) begin
                    len = 16'($urandom_range(1, 0));
                end else if (pick < 20) begin
                    len     = 16'($urandom_range(65535, 5));
                    abandon = 1'b1;
                end else if (pick < 88) begin
                    len = 16'($urandom_range(12, 2));
                end else begin
                    len = 16'($urandom_range(60, 13));
                end
                send_word(KIND_START, 14'($urandom_range(16383)), len,
                          8'($urandom_range(255)));
                random_words++;
                if (abandon) begin
                    ndata = $urandom_range(3, 0);
                end else begin
                    ndata = (len >= 16'd2) ? int'(len) - 1 : 0;
                end
                for (int k = 0; k < ndata; k++) begin
                    send_word(KIND_DATA, 14'($urandom_range(16383)),
                              16'($urandom_range(65535)), 8'($urandom_range(255)));
                    random_words++;
                end
            end
            // A short packet closes anything left open before the next setup.
            send_word(KIND_START, 14'($urandom_range(16383)), 16'($urandom_range(1, 0)),
                      8'($urandom_range(255)));
            random_words++;
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.report_leftover();

        $display("Covered %0d closed packets (%0d short), %0d abandoned, %0d strays dropped.",
                 sb.packets_closed, sb.short_packets, sb.abandoned, sb.strays);
        $display("Checked %0d framed bytes across %0d register writes.",
                 sb.bytes_checked, cfg_writes);
        if (sb.errors == 0) begin
            $display("tb_space_packet_framer_crc16_unit passed");
        end else begin
            $display("tb_space_packet_framer_crc16_unit failed");
        end
        $finish;
    end

    // Far beyond the slowest legal run: every word waiting out the longest stalls.
    initial begin
        #80_000_000;
        $display("tb_space_packet_framer_crc16_unit failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/spf_pkg.sv
rtl/spf_front.sv
rtl/spf_cmd_queue.sv
rtl/spf_back.sv
rtl/space_packet_framer_crc16_unit.sv
dv/spf_tb_pkg.sv
dv/tb_space_packet_framer_crc16_unit.sv
